### src/sakf_pkg.sv
// Package for the scalar adaptive Kalman filter: widths, reset values,
// register indexes, controller states and the controller-to-datapath command bundle.
// No dependencies.
package sakf_pkg;

  localparam int SAMPLE_W = 24;
  localparam int EST_W    = 32;
  localparam int ERR_W    = 32;
  localparam int RNOISE_W = 32;
  localparam int QNOISE_W = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int GAIN_W   = 17;   // Q0.16 gain, 0..65536
  localparam int DEN_W    = 33;   // error + measurement noise, exact
  localparam int MAG_W    = 33;   // magnitude of (sample*256 - estimate)
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int T2_W     = PROD_W - 8;

  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [RNOISE_W-1:0] MEAS_NOISE_RESET = 32'd65536000;
  localparam logic [ERR_W-1:0]    INIT_ERROR_RESET = 32'd5242880;
  localparam logic [QNOISE_W-1:0] PROC_NOISE_RESET = 16'd26214;
  localparam logic [GAIN_W-1:0]   GAIN_ONE         = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAS_NOISE = 2'd0,
    CFG_INIT_ERROR = 2'd1,
    CFG_PROC_NOISE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_STEP,
    ST_MUL_ERR,
    ST_MUL_Q,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MUL_STEP_OP,
    MUL_ERR_OP,
    MUL_Q_OP
  } mul_op_t;

  typedef struct packed {
    logic    load;       // capture sample, set up divider
    logic    div_step;   // one restoring-division step
    logic    div_first;  // first step shifts in error bit 0
    logic    mul_en;     // register a product
    mul_op_t mul_sel;
    logic    cap_smag;   // round step magnitude from product
    logic    cap_t1;     // round decayed error from product
    logic    commit;     // update estimate and error
  } dp_cmd_t;

endpackage

### src/sakf_if.sv
// Stream interfaces for the scalar adaptive Kalman filter: sample in, result out.
// Depends on sakf_pkg.
interface sakf_in_if import sakf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sakf_out_if import sakf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic [ERR_W-1:0]        error_estimate;

  modport source (output valid, output estimate, output error_estimate, input ready);
  modport sink (input valid, input estimate, input error_estimate, output ready);
endinterface

### src/sakf_ctrl.sv
// Sequencer for the scalar adaptive Kalman filter: issues divider and multiplier
// commands and owns the handshakes. Depends on sakf_pkg.
module sakf_ctrl import sakf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_MUL_STEP;
      end
      ST_MUL_STEP: state_nxt = ST_MUL_ERR;
      ST_MUL_ERR:  state_nxt = ST_MUL_Q;
      ST_MUL_Q:    state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_STEP_OP;
    case (state_r)
      ST_IDLE: cmd.load = in_valid;
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
      end
      ST_MUL_STEP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_STEP_OP;
      end
      ST_MUL_ERR: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_ERR_OP;
        cmd.cap_smag = 1'b1;
      end
      ST_MUL_Q: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Q_OP;
        cmd.cap_t1  = 1'b1;
      end
      ST_FIN: cmd.commit = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_DIV) && (cnt_r == '0))
    else $error("divider did not start after sample transfer");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> out_free)
    else $error("result committed over an untaken result");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r || (state_r == ST_IDLE))
    else $error("input ready outside idle");

endmodule

### src/sakf_dp.sv
// Datapath for the scalar adaptive Kalman filter: config registers, filter state,
// serial gain divider and one shared 33x17 multiplier. Depends on sakf_pkg.
module sakf_dp import sakf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_idx,
  input  logic [CFG_W-1:0]           cfg_data,
  input  dp_cmd_t                    cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [EST_W-1:0]    estimate,
  output logic [ERR_W-1:0]           error_estimate
);

  logic [RNOISE_W-1:0] meas_noise_r;
  logic [QNOISE_W-1:0] proc_noise_r;
  logic [EST_W-1:0]    est_r;
  logic [ERR_W-1:0]    err_r;

  logic [DEN_W-1:0]    den_r;
  logic                den_zero_r;
  logic                e_lsb_r;
  logic [DEN_W-1:0]    rem_r;
  logic [GAIN_W-1:0]   quo_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [PROD_W-1:0]   prod_r;
  logic [MAG_W-1:0]    smag_r;
  logic [ERR_W-1:0]    t1_r;

  logic signed [DEN_W-1:0] diff;
  logic [DEN_W:0]      trial;
  logic [GAIN_W-1:0]   gain;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   rnd16;
  logic [PROD_W-1:0]   rnd8;
  logic [T2_W-1:0]     err_sum;
  logic [EST_W+1:0]    est_sum;

  // sample*256 - estimate, exact in 33 bits
  assign diff  = $signed({sample[SAMPLE_W-1], sample, 8'h00}) - $signed({est_r[EST_W-1], est_r});
  assign trial = {rem_r, cmd.div_first ? e_lsb_r : 1'b0};
  assign gain  = den_zero_r ? '0 : quo_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP_OP: begin
        mul_a = mag_r;
        mul_b = gain;
      end
      MUL_ERR_OP: begin
        mul_a = {1'b0, err_r};
        mul_b = GAIN_ONE - gain;
      end
      MUL_Q_OP: begin
        mul_a = smag_r;
        mul_b = {1'b0, proc_noise_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd16   = prod_r + PROD_W'(32768);
  assign rnd8    = prod_r + PROD_W'(128);
  assign err_sum = T2_W'(t1_r) + rnd8[PROD_W-1:8];
  assign est_sum = neg_r ? {{2{est_r[EST_W-1]}}, est_r} - {1'b0, smag_r}
                         : {{2{est_r[EST_W-1]}}, est_r} + {1'b0, smag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_noise_r <= MEAS_NOISE_RESET;
      proc_noise_r <= PROC_NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MEAS_NOISE: meas_noise_r <= cfg_data[RNOISE_W-1:0];
        CFG_PROC_NOISE: proc_noise_r <= cfg_data[QNOISE_W-1:0];
        // reset restores the initial error, so a written value never reaches the state
        CFG_INIT_ERROR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      err_r <= INIT_ERROR_RESET;
    end else if (cmd.commit) begin
      est_r <= est_sum[EST_W-1:0];
      err_r <= (|err_sum[T2_W-1:ERR_W]) ? '1 : err_sum[ERR_W-1:0];
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r      <= {1'b0, err_r} + {1'b0, meas_noise_r};
      den_zero_r <= (err_r == '0) && (meas_noise_r == '0);
      e_lsb_r    <= err_r[0];
      rem_r      <= DEN_W'(err_r >> 1);
      quo_r      <= '0;
      neg_r      <= diff[DEN_W-1];
      mag_r      <= diff[DEN_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
        quo_r <= {quo_r[GAIN_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        quo_r <= {quo_r[GAIN_W-2:0], 1'b0};
      end
    end
    if (cmd.mul_en)   prod_r <= mul_a * mul_b;
    if (cmd.cap_smag) smag_r <= rnd16[MAG_W+15:16];
    if (cmd.cap_t1)   t1_r   <= rnd16[ERR_W+15:16];
  end

  assign estimate       = $signed(est_r);
  assign error_estimate = err_r;

endmodule

### src/scalar_adaptive_kalman_filter.sv
// Top level of the scalar adaptive Kalman filter.
// Depends on sakf_pkg, sakf_if, sakf_ctrl and sakf_dp.

// Smooths signed 24-bit load-cell samples with a one-dimensional Kalman filter.
// Each sample transfer yields one result: the new estimate (signed Q24.8) and the
// new error (unsigned Q16.16, saturating). One sample is in flight at a time: a
// sample passes from its transfer to its registered result through the
// 17-step restoring divider that forms the gain, the three passes through
// the shared multiplier and a commit. The filter is idle again after the
// commit, so it takes a new sample only once the last is done. The next sample is
// taken as soon as that finishes, even while the previous result still waits on
// out_ch; its own commit then waits until that result has gone. Registers:
// index 0 measurement noise (Q16.16), index 1 initial error (reset restores its
// default, so it is accepted and has no effect), index 2 process noise (Q0.16).
// Write configuration only while the filter is idle.
module scalar_adaptive_kalman_filter import sakf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  sakf_in_if.sink              in_ch,
  sakf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t cmd;

  // controller: sequencing and both handshakes
  sakf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: state registers hold the presented result until the next commit
  sakf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sample         (in_ch.sample),
    .estimate       (out_ch.estimate),
    .error_estimate (out_ch.error_estimate)
  );

endmodule
